/* sv/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the slerp datapath.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define QS_ASSERT_NOW(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("slerp assertion failed");

// next-cycle implication, disabled while in reset
`define QS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("slerp assertion failed");

`endif

/* sv/qs_pkg.sv */
// ----------------------------------------------------------------------------
// qs_pkg
// Types, constants and helper functions for the quaternion slerp pipeline.
// ----------------------------------------------------------------------------
package qs_pkg;

    localparam int FRAC_BITS    = 14;
    localparam int CORDIC_STEPS = 16;
    localparam int WB           = 30;
    localparam int TBL          = 32;
    localparam int NSTEPS       = (CORDIC_STEPS < TBL) ? CORDIC_STEPS : TBL;
    localparam int SQ_STEPS     = WB + 1;
    localparam int DIV_BITS     = WB + 3;

    localparam logic signed [33:0] PI_Q      = 34'sd3373259426;
    localparam logic signed [33:0] HALF_PI_Q = 34'sd1686629713;

    typedef enum logic {
        CM_VECTOR,
        CM_ROTATE
    } t_cmode;

    // request sideband carried along the whole chain
    typedef struct packed {
        logic        [14:0]      tau;
        logic        [3:0][15:0] st;
        logic        [3:0][15:0] en;
        logic                    byp;
        logic                    deg;
        logic        [2:0][31:0] rv;
        logic signed [31:0]      w;
        logic        [30:0]      sh;
        logic                    flip;
        logic signed [33:0]      cs;
        logic        [2:0]       neg;
        logic        [2:0]       ovf;
    } t_side;

    typedef struct packed {
        logic signed [33:0] x;
        logic signed [33:0] y;
        logic signed [33:0] z;
    } t_cvec;

    typedef struct packed {
        logic signed [15:0] w;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
        logic               deg;
    } t_res;

    // atan(2^-i) in Q.30
    function automatic logic [29:0] atan_q(input logic [4:0] i);
        logic [29:0] v;
        case (i)
            5'd0:    v = 30'd843314857;
            5'd1:    v = 30'd497837829;
            5'd2:    v = 30'd263043837;
            5'd3:    v = 30'd133525159;
            5'd4:    v = 30'd67021687;
            5'd5:    v = 30'd33543516;
            5'd6:    v = 30'd16775851;
            5'd7:    v = 30'd8388437;
            5'd8:    v = 30'd4194283;
            5'd9:    v = 30'd2097149;
            5'd31:   v = 30'd0;
            default: v = 30'd1 << (5'd30 - i);
        endcase
        return v;
    endfunction

    function automatic logic [63:0] gain_sq(input int n);
        logic [63:0] g;
        g = 64'd1 << 60;
        for (int i = 0; i < n; i++) g = g + (g >> (2 * i));
        return g;
    endfunction

    function automatic logic [63:0] isqrt_c(input logic [63:0] v);
        logic [63:0] x;
        logic [63:0] r;
        logic [63:0] b;
        x = v;
        r = 64'd0;
        b = 64'd1 << 62;
        for (int i = 0; i < 32; i++) begin
            if (x >= r + b) begin
                x = x - (r + b);
                r = (r >> 1) + b;
            end else begin
                r = r >> 1;
            end
            b = b >> 2;
        end
        return r;
    endfunction

    localparam logic [63:0] GAIN_Q   = isqrt_c(gain_sq(NSTEPS));
    localparam logic [63:0] INV_GAIN = ((64'd1 << 60) + GAIN_Q / 2) / GAIN_Q;

    function automatic logic signed [31:0] m16(input logic signed [15:0] a,
                                               input logic signed [15:0] b);
        return 32'(a) * 32'(b);
    endfunction

    function automatic logic signed [49:0] m34(input logic signed [33:0] a,
                                               input logic signed [15:0] b);
        return 50'(a) * 50'(b);
    endfunction

    function automatic logic signed [31:0] sat_unit(input logic signed [35:0] v);
        logic signed [35:0] lim;
        lim = 36'sd1 <<< WB;
        if (v > lim) return 32'(lim);
        if (v < -lim) return 32'(-lim);
        return 32'(v);
    endfunction

    function automatic logic signed [15:0] sat_one(input logic signed [21:0] v);
        logic signed [21:0] lim;
        lim = 22'sd1 <<< FRAC_BITS;
        if (v > lim) return 16'(lim);
        if (v < -lim) return 16'(-lim);
        return 16'(v);
    endfunction

endpackage

/* sv/qs_sqrt_cell.sv */
// ----------------------------------------------------------------------------
// qs_sqrt_cell
// One bit of a pipelined restoring square root (two radicand bits per cell).
// ----------------------------------------------------------------------------
module qs_sqrt_cell
    import qs_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_en,
    input  logic [4:0]  i_step,
    input  logic        i_valid,
    input  t_side       i_side,
    input  logic [61:0] i_rad,
    input  logic [61:0] i_root,
    output logic        o_valid,
    output t_side       o_side,
    output logic [61:0] o_rad,
    output logic [61:0] o_root
);

    logic        r_valid;
    t_side       r_side;
    logic [61:0] r_rad;
    logic [61:0] r_root;
    logic [61:0] n_rad;
    logic [61:0] n_root;
    logic [61:0] bit_w;
    logic [61:0] trial;
    logic [5:0]  sft;

    always_comb begin
        sft   = 6'(2 * WB) - {i_step, 1'b0};
        bit_w = 62'd1 << sft;
        trial = i_root + bit_w;
        if (i_rad >= trial) begin
            n_rad  = i_rad - trial;
            n_root = (i_root >> 1) + bit_w;
        end else begin
            n_rad  = i_rad;
            n_root = i_root >> 1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_side  <= i_side;
            r_rad   <= n_rad;
            r_root  <= n_root;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rad   = r_rad;
    assign o_root  = r_root;

endmodule

/* sv/qs_cordic_cell.sv */
// ----------------------------------------------------------------------------
// qs_cordic_cell
// One CORDIC micro-rotation, vectoring or rotation mode.
// ----------------------------------------------------------------------------
module qs_cordic_cell
    import qs_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_en,
    input  t_cmode     i_mode,
    input  logic [4:0] i_step,
    input  logic       i_valid,
    input  t_side      i_side,
    input  t_cvec      i_vec,
    output logic       o_valid,
    output t_side      o_side,
    output t_cvec      o_vec
);

    logic               r_valid;
    t_side              r_side;
    t_cvec              r_vec;
    t_cvec              n_vec;
    logic signed [33:0] xs;
    logic signed [33:0] ys;
    logic signed [33:0] ang;
    logic               pos;

    always_comb begin
        xs  = i_vec.x >>> i_step;
        ys  = i_vec.y >>> i_step;
        ang = $signed({4'b0, atan_q(i_step)});
        case (i_mode)
            CM_VECTOR: pos = !i_vec.y[33];
            CM_ROTATE: pos = !i_vec.z[33];
            default:   pos = 1'b0;
        endcase
        // vectoring drives y toward zero, rotation drives z toward zero
        if (i_mode == CM_VECTOR) begin
            n_vec.x = pos ? i_vec.x + ys  : i_vec.x - ys;
            n_vec.y = pos ? i_vec.y - xs  : i_vec.y + xs;
            n_vec.z = pos ? i_vec.z + ang : i_vec.z - ang;
        end else begin
            n_vec.x = pos ? i_vec.x - ys  : i_vec.x + ys;
            n_vec.y = pos ? i_vec.y + xs  : i_vec.y - xs;
            n_vec.z = pos ? i_vec.z - ang : i_vec.z + ang;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_side  <= i_side;
            r_vec   <= n_vec;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_vec   = r_vec;

endmodule

/* sv/qs_div_cell.sv */
// ----------------------------------------------------------------------------
// qs_div_cell
// One quotient bit of three parallel restoring dividers sharing a divisor.
// ----------------------------------------------------------------------------
module qs_div_cell
    import qs_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_en,
    input  logic [5:0]                i_bit,
    input  logic                      i_valid,
    input  t_side                     i_side,
    input  logic [2:0][63:0]          i_rem,
    input  logic [2:0][DIV_BITS-1:0]  i_quo,
    output logic                      o_valid,
    output t_side                     o_side,
    output logic [2:0][63:0]          o_rem,
    output logic [2:0][DIV_BITS-1:0]  o_quo
);

    logic                     r_valid;
    t_side                    r_side;
    logic [2:0][63:0]         r_rem;
    logic [2:0][DIV_BITS-1:0] r_quo;
    logic [2:0][63:0]         n_rem;
    logic [2:0][DIV_BITS-1:0] n_quo;
    logic [63:0]              dsh;

    always_comb begin
        dsh = 64'(i_side.sh) << i_bit;
        for (int k = 0; k < 3; k++) begin
            if (i_rem[k] >= dsh) begin
                n_rem[k] = i_rem[k] - dsh;
                n_quo[k] = i_quo[k] | (DIV_BITS'(1) << i_bit);
            end else begin
                n_rem[k] = i_rem[k];
                n_quo[k] = i_quo[k];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
            r_side  <= i_side;
            r_rem   <= n_rem;
            r_quo   <= n_quo;
        end
    end

    assign o_valid = r_valid;
    assign o_side  = r_side;
    assign o_rem   = r_rem;
    assign o_quo   = r_quo;

endmodule

/* sv/quaternion_slerp_top.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp_top
// Fixed-point quaternion slerp built as chains of square root, CORDIC and
// divider cells.
// ----------------------------------------------------------------------------
//  channel | direction | handshake                   | payload
//  in      | into      | i_in_valid / o_in_stall     | tau, start wxyz, end wxyz
//  out     | out of    | o_out_valid / i_out_stall   | out wxyz, degenerate
//
//  One request per cycle while o_in_stall is low; a request passes the
//  square root, the two CORDIC chains and the divider chain, with registered
//  stages between them; each chain is one registered cell per step.
//  Synchronous active-low reset clears all valid bits; no clearing pass.
//  A two-entry output (register plus skid) lets the chain run while a result
//  waits; the whole chain holds only when both entries are full.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module quaternion_slerp_top
    import qs_pkg::*;
(
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic [14:0]        i_frac_tau,
    input  logic signed [15:0] i_start_w,
    input  logic signed [15:0] i_start_x,
    input  logic signed [15:0] i_start_y,
    input  logic signed [15:0] i_start_z,
    input  logic signed [15:0] i_end_w,
    input  logic signed [15:0] i_end_x,
    input  logic signed [15:0] i_end_y,
    input  logic signed [15:0] i_end_z,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic signed [15:0] o_out_w,
    output logic signed [15:0] o_out_x,
    output logic signed [15:0] o_out_y,
    output logic signed [15:0] o_out_z,
    output logic               o_degenerate
);

    logic en;

    logic  r_sk_v;
    t_res  r_sk;
    logic  r_ov;
    t_res  r_out;

    assign en = !r_sk_v;

    // ---- stage 1: capture, equality, fraction clamp
    logic  r1_v;
    t_side r1_side;
    t_side n1_side;

    always_comb begin
        n1_side     = '0;
        n1_side.tau = (i_frac_tau > 15'(1 << FRAC_BITS)) ? 15'(1 << FRAC_BITS) : i_frac_tau;
        n1_side.st  = {i_start_z, i_start_y, i_start_x, i_start_w};
        n1_side.en  = {i_end_z, i_end_y, i_end_x, i_end_w};
        n1_side.byp = (i_start_w == i_end_w) && (i_start_x == i_end_x)
                   && (i_start_y == i_end_y) && (i_start_z == i_end_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (en) begin
            r1_v    <= i_in_valid;
            r1_side <= n1_side;
        end
    end

    // ---- stage 2: relative rotation r = end * conj(start)
    logic  r2_v;
    t_side r2_side;
    t_side n2_side;
    logic signed [15:0] s0, s1, s2, s3, e0, e1, e2, e3;
    logic signed [33:0] rs0, rs1, rs2, rs3;

    always_comb begin
        s0 = $signed(r1_side.st[0]);
        s1 = $signed(r1_side.st[1]);
        s2 = $signed(r1_side.st[2]);
        s3 = $signed(r1_side.st[3]);
        e0 = $signed(r1_side.en[0]);
        e1 = $signed(r1_side.en[1]);
        e2 = $signed(r1_side.en[2]);
        e3 = $signed(r1_side.en[3]);
        rs0 = 34'(m16(e0, s0)) + 34'(m16(e1, s1)) + 34'(m16(e2, s2)) + 34'(m16(e3, s3));
        rs1 = 34'(m16(e1, s0)) - 34'(m16(e0, s1)) - 34'(m16(e2, s3)) + 34'(m16(e3, s2));
        rs2 = 34'(m16(e2, s0)) - 34'(m16(e0, s2)) + 34'(m16(e1, s3)) - 34'(m16(e3, s1));
        rs3 = 34'(m16(e3, s0)) - 34'(m16(e0, s3)) - 34'(m16(e1, s2)) + 34'(m16(e2, s1));
        n2_side       = r1_side;
        n2_side.w     = sat_unit(36'(rs0) <<< (WB - 2 * FRAC_BITS));
        n2_side.rv[0] = sat_unit(36'(rs1) <<< (WB - 2 * FRAC_BITS));
        n2_side.rv[1] = sat_unit(36'(rs2) <<< (WB - 2 * FRAC_BITS));
        n2_side.rv[2] = sat_unit(36'(rs3) <<< (WB - 2 * FRAC_BITS));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (en) begin
            r2_v    <= r1_v;
            r2_side <= n2_side;
        end
    end

    // ---- stage 3: w squared
    logic               r3_v;
    t_side              r3_side;
    logic signed [63:0] r3_wsq;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (en) begin
            r3_v    <= r2_v;
            r3_side <= r2_side;
            r3_wsq  <= 64'(r2_side.w) * 64'(r2_side.w);
        end
    end

    // ---- square root chain: sin(h) = sqrt(1 - w^2)
    logic        sq_v    [0:SQ_STEPS];
    t_side       sq_side [0:SQ_STEPS];
    logic [61:0] sq_rad  [0:SQ_STEPS];
    logic [61:0] sq_root [0:SQ_STEPS];

    assign sq_v[0]    = r3_v;
    assign sq_side[0] = r3_side;
    assign sq_rad[0]  = (62'd1 << (2 * WB)) - r3_wsq[61:0];
    assign sq_root[0] = '0;

    for (genvar k = 0; k < SQ_STEPS; k++) begin : g_sq
        qs_sqrt_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_step  (5'(k)),
            .i_valid (sq_v[k]),
            .i_side  (sq_side[k]),
            .i_rad   (sq_rad[k]),
            .i_root  (sq_root[k]),
            .o_valid (sq_v[k+1]),
            .o_side  (sq_side[k+1]),
            .o_rad   (sq_rad[k+1]),
            .o_root  (sq_root[k+1])
        );
    end

    // ---- vectoring chain: h = atan2(sin h, |w|)
    logic  cv_v    [0:NSTEPS];
    t_side cv_side [0:NSTEPS];
    t_cvec cv_vec  [0:NSTEPS];
    t_side cv_head;

    always_comb begin
        cv_head     = sq_side[SQ_STEPS];
        cv_head.sh  = sq_root[SQ_STEPS][30:0];
        cv_head.deg = (sq_root[SQ_STEPS] == '0);
    end

    assign cv_side[0]  = cv_head;
    assign cv_vec[0].x = sq_side[SQ_STEPS].w[31] ? -34'(sq_side[SQ_STEPS].w)
                                                 : 34'(sq_side[SQ_STEPS].w);
    assign cv_vec[0].y = $signed({3'b0, sq_root[SQ_STEPS][30:0]});
    assign cv_vec[0].z = '0;
    assign cv_v[0]     = sq_v[SQ_STEPS];

    for (genvar k = 0; k < NSTEPS; k++) begin : g_vec
        qs_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_mode  (CM_VECTOR),
            .i_step  (5'(k)),
            .i_valid (cv_v[k]),
            .i_side  (cv_side[k]),
            .i_vec   (cv_vec[k]),
            .o_valid (cv_v[k+1]),
            .o_side  (cv_side[k+1]),
            .o_vec   (cv_vec[k+1])
        );
    end

    // ---- stage 4: h and tau * h
    logic               r4_v;
    t_side              r4_side;
    logic signed [33:0] r4_th;
    logic signed [33:0] hang;
    logic signed [49:0] hprod;

    always_comb begin
        hang  = cv_side[NSTEPS].w[31] ? PI_Q - cv_vec[NSTEPS].z : cv_vec[NSTEPS].z;
        hprod = 50'(hang) * $signed({35'b0, cv_side[NSTEPS].tau});
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r4_v <= 1'b0;
        end else if (en) begin
            r4_v    <= cv_v[NSTEPS];
            r4_side <= cv_side[NSTEPS];
            r4_th   <= 34'((hprod + (50'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
    end

    // ---- stage 5: fold the angle into the first quadrant
    logic               r5_v;
    t_side              r5_side;
    t_side              n5_side;
    logic signed [33:0] r5_a;
    logic               fl;

    assign fl = r4_th > HALF_PI_Q;

    always_comb begin
        n5_side      = r4_side;
        n5_side.flip = fl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r5_v <= 1'b0;
        end else if (en) begin
            r5_v    <= r4_v;
            r5_side <= n5_side;
            r5_a    <= fl ? PI_Q - r4_th : r4_th;
        end
    end

    // ---- rotation chain: cos and sin of tau * h
    logic  cr_v    [0:NSTEPS];
    t_side cr_side [0:NSTEPS];
    t_cvec cr_vec  [0:NSTEPS];

    assign cr_v[0]     = r5_v;
    assign cr_side[0]  = r5_side;
    assign cr_vec[0].x = $signed(INV_GAIN[33:0]);
    assign cr_vec[0].y = '0;
    assign cr_vec[0].z = r5_a;

    for (genvar k = 0; k < NSTEPS; k++) begin : g_rot
        qs_cordic_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_mode  (CM_ROTATE),
            .i_step  (5'(k)),
            .i_valid (cr_v[k]),
            .i_side  (cr_side[k]),
            .i_vec   (cr_vec[k]),
            .o_valid (cr_v[k+1]),
            .o_side  (cr_side[k+1]),
            .o_vec   (cr_vec[k+1])
        );
    end

    // ---- stage 6: numerators r.v * sin(tau h)
    logic                    r6_v;
    t_side                   r6_side;
    t_side                   n6_side;
    logic [2:0][63:0]        r6_num;
    logic signed [65:0]      nprod [3];

    always_comb begin
        n6_side    = cr_side[NSTEPS];
        n6_side.cs = cr_side[NSTEPS].flip ? -cr_vec[NSTEPS].x : cr_vec[NSTEPS].x;
        for (int k = 0; k < 3; k++) begin
            nprod[k] = 66'($signed(cr_side[NSTEPS].rv[k])) * 66'(cr_vec[NSTEPS].y);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r6_v <= 1'b0;
        end else if (en) begin
            r6_v    <= cr_v[NSTEPS];
            r6_side <= n6_side;
            for (int k = 0; k < 3; k++) r6_num[k] <= nprod[k][63:0];
        end
    end

    // ---- stage 7: magnitudes and quotient overflow
    logic                     r7_v;
    t_side                    r7_side;
    logic [2:0][63:0]         r7_mag;
    logic [2:0][63:0]         mag;
    t_side                    n7_side;

    always_comb begin
        n7_side = r6_side;
        for (int k = 0; k < 3; k++) begin
            n7_side.neg[k] = r6_num[k][63];
            mag[k]         = r6_num[k][63] ? 64'(0) - r6_num[k] : r6_num[k];
            n7_side.ovf[k] = (mag[k] >> DIV_BITS) >= 64'(r6_side.sh);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r7_v <= 1'b0;
        end else if (en) begin
            r7_v    <= r6_v;
            r7_side <= n7_side;
            r7_mag  <= mag;
        end
    end

    // ---- divider chain: scale by 1 / sin(h)
    logic                     dv_v    [0:DIV_BITS];
    t_side                    dv_side [0:DIV_BITS];
    logic [2:0][63:0]         dv_rem  [0:DIV_BITS];
    logic [2:0][DIV_BITS-1:0] dv_quo  [0:DIV_BITS];

    assign dv_v[0]    = r7_v;
    assign dv_side[0] = r7_side;
    assign dv_rem[0]  = r7_mag;
    assign dv_quo[0]  = '0;

    for (genvar k = 0; k < DIV_BITS; k++) begin : g_div
        qs_div_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_bit   (6'(DIV_BITS - 1 - k)),
            .i_valid (dv_v[k]),
            .i_side  (dv_side[k]),
            .i_rem   (dv_rem[k]),
            .i_quo   (dv_quo[k]),
            .o_valid (dv_v[k+1]),
            .o_side  (dv_side[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_quo   (dv_quo[k+1])
        );
    end

    // ---- stage 8: clamp quotients to +-4.0 and restore sign
    logic                    r8_v;
    t_side                   r8_side;
    logic [2:0][33:0]        r8_q;
    logic [DIV_BITS-1:0]     qm [3];
    localparam logic [DIV_BITS-1:0] QLIM = DIV_BITS'(1) << (WB + 2);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            qm[k] = (dv_side[DIV_BITS].ovf[k] || dv_quo[DIV_BITS][k] > QLIM)
                  ? QLIM : dv_quo[DIV_BITS][k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r8_v <= 1'b0;
        end else if (en) begin
            r8_v    <= dv_v[DIV_BITS];
            r8_side <= dv_side[DIV_BITS];
            for (int k = 0; k < 3; k++) begin
                r8_q[k] <= dv_side[DIV_BITS].neg[k] ? 34'(0) - 34'(qm[k]) : 34'(qm[k]);
            end
        end
    end

    // ---- stage 9: multiply by start, round, pick the result
    logic               r9_v;
    t_res               r9_res;
    t_res               n9_res;
    logic signed [33:0] q0, q1, q2, q3;
    logic signed [15:0] t0, t1, t2, t3;
    logic signed [51:0] o0, o1, o2, o3;
    logic signed [51:0] rnd;

    always_comb begin
        q0 = r8_side.cs;
        q1 = $signed(r8_q[0]);
        q2 = $signed(r8_q[1]);
        q3 = $signed(r8_q[2]);
        t0 = $signed(r8_side.st[0]);
        t1 = $signed(r8_side.st[1]);
        t2 = $signed(r8_side.st[2]);
        t3 = $signed(r8_side.st[3]);
        rnd = 52'sd1 <<< (WB - 1);
        o0 = 52'(m34(q0, t0)) - 52'(m34(q1, t1)) - 52'(m34(q2, t2)) - 52'(m34(q3, t3));
        o1 = 52'(m34(q0, t1)) + 52'(m34(q1, t0)) + 52'(m34(q2, t3)) - 52'(m34(q3, t2));
        o2 = 52'(m34(q0, t2)) - 52'(m34(q1, t3)) + 52'(m34(q2, t0)) + 52'(m34(q3, t1));
        o3 = 52'(m34(q0, t3)) + 52'(m34(q1, t2)) - 52'(m34(q2, t1)) + 52'(m34(q3, t0));
        if (r8_side.byp || r8_side.deg) begin
            n9_res.w   = sat_one(22'($signed(r8_side.en[0])));
            n9_res.x   = sat_one(22'($signed(r8_side.en[1])));
            n9_res.y   = sat_one(22'($signed(r8_side.en[2])));
            n9_res.z   = sat_one(22'($signed(r8_side.en[3])));
            n9_res.deg = !r8_side.byp;
        end else begin
            n9_res.w   = sat_one(22'((o0 + rnd) >>> WB));
            n9_res.x   = sat_one(22'((o1 + rnd) >>> WB));
            n9_res.y   = sat_one(22'((o2 + rnd) >>> WB));
            n9_res.z   = sat_one(22'((o3 + rnd) >>> WB));
            n9_res.deg = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r9_v <= 1'b0;
        end else if (en) begin
            r9_v   <= r8_v;
            r9_res <= n9_res;
        end
    end

    // ---- output register and skid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov   <= 1'b0;
            r_sk_v <= 1'b0;
        end else if (!r_ov || !i_out_stall) begin
            if (r_sk_v) begin
                r_ov   <= 1'b1;
                r_out  <= r_sk;
                r_sk_v <= 1'b0;
            end else begin
                r_ov  <= r9_v;
                r_out <= r9_res;
            end
        end else if (r9_v && !r_sk_v) begin
            // output held: park the finishing request
            r_sk_v <= 1'b1;
            r_sk   <= r9_res;
        end
    end

    assign o_in_stall   = r_sk_v;
    assign o_out_valid  = r_ov;
    assign o_out_w      = r_out.w;
    assign o_out_x      = r_out.x;
    assign o_out_y      = r_out.y;
    assign o_out_z      = r_out.z;
    assign o_degenerate = r_out.deg;

    `QS_ASSERT_NOW(a_skid_behind_out, i_clk, i_rst_n, r_sk_v, r_ov)
    `QS_ASSERT_NEXT(a_frozen_tail, i_clk, i_rst_n, !en, $stable(r9_res) && $stable(r9_v))
    `QS_ASSERT_NEXT(a_skid_drains, i_clk, i_rst_n, r_sk_v && !i_out_stall, r_ov && !r_sk_v)

endmodule

/* dv/quaternion_slerp_top_test.sv */
// ----------------------------------------------------------------------------
// quaternion_slerp_top_test
// Self-checking bench for the slerp pipeline: drives start/end quaternion
// pairs with a fraction, predicts every result in fixed point and compares
// each output field, under random sender and receiver idling.
// ----------------------------------------------------------------------------
module quaternion_slerp_top_test;
    import qs_pkg::*;

    typedef longint quat_l[4];
    typedef int     quat_i[4];

    localparam int IDLE_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 130;

    class slerp_scoreboard;
        longint atan_q30[16];
        longint pi_q30;
        longint half_pi_q30;
        longint inv_gain_q30;
        t_res   expected_q[$];
        int     n_req;
        int     n_res;
        int     n_deg;
        int     n_err;

        function new();
            longint unsigned a1;
            longint unsigned g;
            longint unsigned gq;
            a1 = atan_inv(2) + atan_inv(3);
            atan_q30[0] = longint'((a1 + (64'd1 << 31)) >> 32);
            for (int i = 1; i < 16; i++)
                atan_q30[i] = longint'((atan_inv(64'd1 << i) + (64'd1 << 31)) >> 32);
            pi_q30      = longint'((4 * a1 + (64'd1 << 31)) >> 32);
            half_pi_q30 = longint'((2 * a1 + (64'd1 << 31)) >> 32);
            g = 64'd1 << 60;
            for (int i = 0; i < 16; i++) g = g + (g >> (2 * i));
            gq = int_sqrt(g);
            inv_gain_q30 = longint'(((64'd1 << 60) + gq / 2) / gq);
        endfunction

        // atan(1/den) in Q.62 from the alternating series
        function longint unsigned atan_inv(longint unsigned den);
            longint unsigned p;
            longint unsigned d2;
            longint unsigned sum;
            longint unsigned k;
            longint unsigned term;
            bit sub;
            p = (64'd1 << 62) / den;
            d2 = den * den;
            sum = p;
            k = 1;
            sub = 1;
            forever begin
                p = p / d2;
                if (p == 0) break;
                term = p / (2 * k + 1);
                sum = sub ? sum - term : sum + term;
                sub = !sub;
                k++;
            end
            return sum;
        endfunction

        function longint unsigned int_sqrt(longint unsigned v);
            longint unsigned rem;
            longint unsigned root;
            longint unsigned b;
            rem = v;
            root = 0;
            b = 64'd1 << 62;
            for (int i = 0; i < 32; i++) begin
                if (rem >= root + b) begin
                    rem = rem - (root + b);
                    root = (root >> 1) + b;
                end else begin
                    root = root >> 1;
                end
                b = b >> 2;
            end
            return root;
        endfunction

        function longint clip(longint v, longint lim);
            return v > lim ? lim : (v < -lim ? -lim : v);
        endfunction

        function longint round_shr(longint v, int s);
            return (v + (longint'(1) << (s - 1))) >>> s;
        endfunction

        function void hamilton(quat_l a, quat_l b, output quat_l o);
            o[0] = a[0] * b[0] - a[1] * b[1] - a[2] * b[2] - a[3] * b[3];
            o[1] = a[0] * b[1] + a[1] * b[0] + a[2] * b[3] - a[3] * b[2];
            o[2] = a[0] * b[2] - a[1] * b[3] + a[2] * b[0] + a[3] * b[1];
            o[3] = a[0] * b[3] + a[1] * b[2] - a[2] * b[1] + a[3] * b[0];
        endfunction

        function t_res pack_res(quat_l q, bit deg);
            t_res res;
            res.w = 16'(clip(q[0], 16384));
            res.x = 16'(clip(q[1], 16384));
            res.y = 16'(clip(q[2], 16384));
            res.z = 16'(clip(q[3], 16384));
            res.deg = deg;
            return res;
        endfunction

        function t_res slerp(longint tau_in, quat_l st, quat_l en);
            quat_l conj_st;
            quat_l rel;
            quat_l part;
            quat_l prod;
            longint tau;
            longint w;
            longint x;
            longint y;
            longint z;
            longint xn;
            longint h;
            longint th;
            longint a;
            longint c;
            longint sn;
            longint sh;
            bit flip;
            tau = tau_in > 16384 ? 16384 : tau_in;
            if (st[0] == en[0] && st[1] == en[1] && st[2] == en[2] && st[3] == en[3])
                return pack_res(en, 0);
            conj_st[0] = st[0];
            for (int k = 1; k < 4; k++) conj_st[k] = -st[k];
            hamilton(en, conj_st, rel);
            for (int k = 0; k < 4; k++) rel[k] = clip(rel[k] * 4, longint'(1) << 30);
            w = rel[0];
            sh = longint'(int_sqrt((64'd1 << 60) - longint'(w * w)));
            if (sh == 0) return pack_res(en, 1);
            // vectoring pass: angle of (|w|, sin h)
            x = w < 0 ? -w : w;
            y = sh;
            z = 0;
            for (int i = 0; i < 16; i++) begin
                xn = x;
                if (y >= 0) begin
                    x += y >>> i; y -= xn >>> i; z += atan_q30[i];
                end else begin
                    x -= y >>> i; y += xn >>> i; z -= atan_q30[i];
                end
            end
            h = w < 0 ? pi_q30 - z : z;
            th = round_shr(h * tau, 14);
            flip = th > half_pi_q30;
            a = flip ? pi_q30 - th : th;
            x = inv_gain_q30;
            y = 0;
            z = a;
            for (int i = 0; i < 16; i++) begin
                xn = x;
                if (z >= 0) begin
                    x -= y >>> i; y += xn >>> i; z -= atan_q30[i];
                end else begin
                    x += y >>> i; y -= xn >>> i; z += atan_q30[i];
                end
            end
            c = flip ? -x : x;
            sn = y;
            part[0] = c;
            for (int k = 1; k < 4; k++) part[k] = clip((rel[k] * sn) / sh, longint'(4) << 30);
            hamilton(part, st, prod);
            for (int k = 0; k < 4; k++) prod[k] = round_shr(prod[k], 30);
            return pack_res(prod, 0);
        endfunction

        function void note_request(int tau, quat_i st, quat_i en);
            quat_l s;
            quat_l e;
            t_res res;
            for (int k = 0; k < 4; k++) begin
                s[k] = st[k];
                e[k] = en[k];
            end
            res = slerp(tau, s, e);
            if (res.deg) n_deg++;
            expected_q.push_back(res);
            n_req++;
        endfunction

        function void check_result(t_res got);
            t_res want;
            n_res++;
            if (expected_q.size() == 0) begin
                n_err++;
                if (n_err <= 10) $display("unexpected result w=%0d x=%0d y=%0d z=%0d deg=%0b",
                                          got.w, got.x, got.y, got.z, got.deg);
                return;
            end
            want = expected_q.pop_front();
            if (got !== want) begin
                n_err++;
                if (n_err <= 10)
                    $display("mismatch #%0d: exp w=%0d x=%0d y=%0d z=%0d deg=%0b, got w=%0d x=%0d y=%0d z=%0d deg=%0b",
                             n_res, want.w, want.x, want.y, want.z, want.deg,
                             got.w, got.x, got.y, got.z, got.deg);
            end
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic               i_clk;
    logic               i_rst_n;
    logic               i_in_valid;
    logic               o_in_stall;
    logic [14:0]        i_frac_tau;
    logic signed [15:0] i_start_w;
    logic signed [15:0] i_start_x;
    logic signed [15:0] i_start_y;
    logic signed [15:0] i_start_z;
    logic signed [15:0] i_end_w;
    logic signed [15:0] i_end_x;
    logic signed [15:0] i_end_y;
    logic signed [15:0] i_end_z;
    logic               o_out_valid;
    logic               i_out_stall;
    logic signed [15:0] o_out_w;
    logic signed [15:0] o_out_x;
    logic signed [15:0] o_out_y;
    logic signed [15:0] o_out_z;
    logic               o_degenerate;

    slerp_scoreboard sb = new();
    int snd_idle_pct;
    int rcv_idle_pct;
    int quiet_cycles;

    quaternion_slerp_top uut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    // receiver stall, changed on the falling edge
    always @(negedge i_clk) begin
        i_out_stall <= (i_rst_n === 1'b1) && ($urandom_range(99) < rcv_idle_pct);
    end

    always @(posedge i_clk) begin
        t_res got;
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0) begin
            got.w = o_out_w;
            got.x = o_out_x;
            got.y = o_out_y;
            got.z = o_out_z;
            got.deg = o_degenerate;
            sb.check_result(got);
        end
        if ((i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        quiet_cycles = 0;
        @(posedge i_clk);
        while (quiet_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("timeout: no request or result moved for %0d cycles", IDLE_LIMIT);
        $display("quaternion_slerp_top_test: FAIL");
        $finish;
    end

    task automatic send(int tau, quat_i st, quat_i en);
        while ($urandom_range(99) < snd_idle_pct) begin
            i_in_valid = 1'b0;
            @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_frac_tau = 15'(tau);
        {i_start_w, i_start_x, i_start_y, i_start_z} =
            {16'(st[0]), 16'(st[1]), 16'(st[2]), 16'(st[3])};
        {i_end_w, i_end_x, i_end_y, i_end_z} =
            {16'(en[0]), 16'(en[1]), 16'(en[2]), 16'(en[3])};
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        sb.note_request(tau, st, en);
        @(negedge i_clk);
        i_in_valid = 1'b0;
    endtask

    function automatic void rand_unit(output quat_i q);
        real v[4];
        real n;
        do begin
            n = 0.0;
            for (int k = 0; k < 4; k++) begin
                v[k] = real'(int'($urandom_range(2000)) - 1000);
                n += v[k] * v[k];
            end
        end while (n < 100.0);
        n = $sqrt(n);
        for (int k = 0; k < 4; k++) begin
            q[k] = int'($rtoi(v[k] / n * 16384.0 + (v[k] < 0 ? -0.5 : 0.5)));
            if (q[k] > 16384) q[k] = 16384;
            if (q[k] < -16384) q[k] = -16384;
        end
    endfunction

    function automatic int rand_tau();
        if ($urandom_range(9) == 0) return $urandom_range(32767, 16385);
        if ($urandom_range(9) == 0) return $urandom_range(1) ? 0 : 16384;
        return $urandom_range(16384);
    endfunction

    task automatic random_request();
        quat_i st;
        quat_i en;
        int pick;
        pick = $urandom_range(99);
        rand_unit(st);
        if (pick < 55) begin
            rand_unit(en);
        end else if (pick < 70) begin
            // nearby end: small angles and near-degenerate sines
            for (int k = 0; k < 4; k++) begin
                en[k] = st[k] + int'($urandom_range(2 << ($urandom_range(8)))) -
                        (1 << ($urandom_range(8)));
                if (en[k] > 16384) en[k] = 16384;
                if (en[k] < -16384) en[k] = -16384;
            end
        end else if (pick < 80) begin
            en = st;
        end else if (pick < 88) begin
            for (int k = 0; k < 4; k++) en[k] = -st[k];
        end else begin
            for (int k = 0; k < 4; k++) begin
                st[k] = $urandom_range(32768) - 16384;
                en[k] = $urandom_range(32768) - 16384;
            end
        end
        send(rand_tau(), st, en);
    endtask

    task automatic directed_requests();
        quat_i ident;
        quat_i rx90;
        quat_i rz90;
        quat_i negi;
        quat_i maxq;
        quat_i minq;
        quat_i odd;
        quat_i ry180;
        ident = '{16384, 0, 0, 0};
        rx90  = '{11585, 11585, 0, 0};
        rz90  = '{11585, 0, 0, 11585};
        negi  = '{-16384, 0, 0, 0};
        maxq  = '{16384, 16384, 16384, 16384};
        minq  = '{-16384, -16384, -16384, -16384};
        odd   = '{5461, -10923, 8191, -12287};
        ry180 = '{0, 0, 16384, 0};
        send(0, ident, rx90);
        send(16384, ident, rx90);
        send(8192, ident, rx90);
        send(8192, rx90, rz90);
        send(32767, rx90, rz90);          // fraction above one
        send(16385, ident, rz90);
        send(12345, rx90, rx90);          // equal quaternions
        send(8192, maxq, maxq);
        send(8192, ident, negi);          // zero sine
        send(8192, rx90, '{-11585, -11585, 0, 0});
        send(8192, ident, '{16383, 1, 0, 0});
        send(4096, ident, ry180);         // half-turn apart
        send(16383, ry180, ident);
        send(8192, maxq, minq);           // non-unit extremes
        send(1, minq, maxq);
        send(10922, odd, rz90);
        send(5461, rz90, odd);
        send(16384, odd, negi);
        send(8192, '{-16384, 16384, -16384, 16384}, '{16384, -16384, 16384, -16384});
        send(21845, '{0, 16384, 0, 0}, '{0, 0, 0, 16384});
    endtask

    initial begin
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_frac_tau = '0;
        {i_start_w, i_start_x, i_start_y, i_start_z} = '0;
        {i_end_w, i_end_x, i_end_y, i_end_z} = '0;
        snd_idle_pct = 21;
        rcv_idle_pct = 64;
        repeat (12) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        directed_requests();
        repeat (600) random_request();
        // hold the sender until the pipe has drained
        while (sb.pending() != 0) @(negedge i_clk);
        snd_idle_pct = 64;
        rcv_idle_pct = 21;
        repeat (600) random_request();
        snd_idle_pct = 0;
        rcv_idle_pct = 0;
        repeat (600) random_request();
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        $display("covered %0d requests and %0d results (%0d degenerate), mismatches %0d",
                 sb.n_req, sb.n_res, sb.n_deg, sb.n_err);
        $display("phases: sender/receiver idling 21/64, 64/21 and none, with one full drain");
        if (sb.n_err == 0 && sb.pending() == 0) begin
            $display("quaternion_slerp_top_test: PASS");
        end else begin
            $display("quaternion_slerp_top_test: FAIL");
        end
        $finish;
    end
endmodule
